[sv/assert_macros.svh]
// assertion macros used by the top-level rtl file
// no dependencies; expects clk and rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, always active
`define PSU_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// clocked assertion, off while reset is asserted
`define PSU_ASSERT(lbl, prop, msg) \
  `PSU_ASSERT_CLK(lbl, disable iff (!rst_n) prop, msg)

`endif

[sv/psu_pkg.sv]
// shared types, codes and the paeth selector for the scanline unfilter
// no dependencies
`default_nettype none

package psu_pkg;

  // filter type codes
  typedef logic [2:0] filt_t;
  localparam filt_t FILT_NONE  = 3'd0;
  localparam filt_t FILT_SUB   = 3'd1;
  localparam filt_t FILT_UP    = 3'd2;
  localparam filt_t FILT_AVG   = 3'd3;
  localparam filt_t FILT_PAETH = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_BPP     = 2'd0;
  localparam logic [1:0] REG_ROW_LEN = 2'd1;
  localparam logic [1:0] REG_ROWS    = 2'd2;

  // raw configuration register contents
  typedef struct packed {
    logic [3:0]  bpp;
    logic [13:0] row_len;
    logic [15:0] rows;
  } cfg_t;

  // paeth predictor with full-precision signed distances, ties to a then b
  function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    logic signed [10:0] sa, sb, sc, p, da, db, dc;
    logic [7:0] res;
    sa = $signed({3'b000, a});
    sb = $signed({3'b000, b});
    sc = $signed({3'b000, c});
    p  = sa + sb - sc;
    da = p - sa;
    db = p - sb;
    dc = p - sc;
    if (da < 0) da = -da;
    if (db < 0) db = -db;
    if (dc < 0) dc = -dc;
    if (da <= db && da <= dc) begin
      res = a;
    end else if (db <= dc) begin
      res = b;
    end else begin
      res = c;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[sv/psu_ram.sv]
// generic single-port-write, registered-read ram
// no dependencies
`default_nettype none

module psu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: a read at the written address returns the old contents
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

`default_nettype wire

[sv/psu_cfg.sv]
// apb-style configuration registers for the scanline unfilter
// depends on psu_pkg
`default_nettype none

module psu_cfg (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic      [31:0]  prdata,
  output logic              pready,
  output psu_pkg::cfg_t     cfg
);
  import psu_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (paddr[3:2])
        REG_BPP:     cfg_nxt.bpp     = pwdata[3:0];
        REG_ROW_LEN: cfg_nxt.row_len = pwdata[13:0];
        REG_ROWS:    cfg_nxt.rows    = pwdata[15:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bpp     <= 4'd1;
      cfg_r.row_len <= 14'd1;
      cfg_r.rows    <= 16'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read mux
  always_comb begin
    case (paddr[3:2])
      REG_BPP:     prdata = {28'd0, cfg_r.bpp};
      REG_ROW_LEN: prdata = {18'd0, cfg_r.row_len};
      REG_ROWS:    prdata = {16'd0, cfg_r.rows};
      default:     prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

[sv/psu_predict.sv]
// byte predictor and reconstruction adder for one filtered byte
// depends on psu_pkg
`default_nettype none

module psu_predict (
  input  wire psu_pkg::filt_t filt,
  input  wire logic [7:0]     x,
  input  wire logic [7:0]     a,
  input  wire logic [7:0]     b,
  input  wire logic [7:0]     c,
  output logic      [7:0]     recon
);
  import psu_pkg::*;

  logic [8:0] avg_sum;
  logic [7:0] pred;

  assign avg_sum = {1'b0, a} + {1'b0, b};

  // select the predictor for this row's filter
  always_comb begin
    case (filt)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = avg_sum[8:1];
      FILT_PAETH: pred = paeth_pick(a, b, c);
      default:    pred = 8'd0;
    endcase
  end

  // modulo-256 add
  assign recon = x + pred;

endmodule

`default_nettype wire

[sv/png_scanline_unfilter.sv]
// png scanline unfilter: top level with stream control, history and row store
// depends on psu_pkg, psu_cfg, psu_predict, psu_ram and assert_macros.svh
//
// Usage:
//   in_valid/in_stall carry the filtered stream one byte per transaction. The
//   first byte of each row is the filter type and yields no result; every
//   following byte yields one reconstructed byte on out_valid/out_stall,
//   tagged with row end, image end and bad filter flags.
//   Configuration goes through the apb-style port (psel, penable, pwrite,
//   paddr, pwdata, prdata, pready) while the stream is idle; the user is
//   bound to this, the block itself does not enforce it. A byte accepted
//   lands in the input register, is reconstructed from there and shows on
//   the output register when the output register is empty or not stalled.
//   Throughput: one byte per cycle while out_stall is low; the loop through
//   the left-neighbor history and the row store (one read and one write per
//   data byte) sets it. When out_stall is high the output register holds,
//   the input register fills behind it, and in_stall rises only when both are
//   occupied. Reset clears the stream control and sets the registers (bytes per
//   pixel 1, row length 1, row count 1); the row store needs no clearing pass.
`default_nettype none
`include "assert_macros.svh"

module png_scanline_unfilter #(
  parameter int MAX_ROW_BYTES = 8192,
  parameter int MAX_BPP       = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_stream_byte,
  // result stream
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_pixel_byte,
  output logic             out_row_end,
  output logic             out_image_end,
  output logic             out_bad_filter,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import psu_pkg::*;

  localparam int CW = $clog2(MAX_ROW_BYTES);
  localparam int LW = (CW + 1 > 15) ? CW + 1 : 15;
  localparam int BW = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;

  cfg_t cfg;

  // effective configuration
  logic [LW-1:0] eff_len;
  logic [3:0]    eff_bpp;
  logic [3:0]    bpp_m1;
  logic [15:0]   eff_rows;

  // input register
  logic       s1_v_r, s1_v_nxt;
  logic [7:0] s1_x_r;
  logic       s1_fire;
  logic       s1_data;
  logic       in_accept;

  // row control
  logic          await_r, await_nxt;
  filt_t         filt_r, filt_nxt;
  logic          bad_r, bad_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [15:0]   row_r, row_nxt;

  // histories: index 0 holds the entry for the most recent data byte
  logic [7:0] lh_r [MAX_BPP];
  logic [7:0] ah_r [MAX_BPP];

  // datapath
  logic [LW-1:0] col_inc;
  logic [15:0]   row_inc;
  logic          have_left, have_above;
  logic          rend, iend;
  logic [7:0]    a, b, c, recon, ram_q;

  // output register
  logic       out_v_r, out_v_nxt;
  logic [7:0] out_pix_r;
  logic       out_rend_r, out_iend_r, out_bad_r;

  psu_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // clamp registers to their working ranges
  always_comb begin
    eff_len = LW'(cfg.row_len);
    if (eff_len == '0) begin
      eff_len = LW'(1);
    end else if (eff_len > LW'(MAX_ROW_BYTES)) begin
      eff_len = LW'(MAX_ROW_BYTES);
    end
    eff_bpp = cfg.bpp;
    if (eff_bpp == 4'd0) begin
      eff_bpp = 4'd1;
    end else if (eff_bpp > 4'(MAX_BPP)) begin
      eff_bpp = 4'(MAX_BPP);
    end
    eff_rows = (cfg.rows == 16'd0) ? 16'd1 : cfg.rows;
  end
  assign bpp_m1 = eff_bpp - 4'd1;

  // handshake
  assign s1_data   = s1_v_r && !await_r;
  assign s1_fire   = s1_v_r && (await_r || !out_v_r || !out_stall);
  assign in_stall  = s1_v_r && !s1_fire;
  assign in_accept = in_valid && !in_stall;
  assign s1_v_nxt  = in_accept || (s1_v_r && !s1_fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_x_r <= in_stream_byte;
    end
  end

  // neighbors
  assign have_left  = LW'(col_r) >= LW'(eff_bpp);
  assign have_above = row_r != 16'd0;
  assign a = have_left ? lh_r[bpp_m1[BW-1:0]] : 8'd0;
  assign b = have_above ? ram_q : 8'd0;
  assign c = (have_left && have_above) ? ah_r[bpp_m1[BW-1:0]] : 8'd0;

  psu_predict u_pred (
    .filt  (filt_r),
    .x     (s1_x_r),
    .a     (a),
    .b     (b),
    .c     (c),
    .recon (recon)
  );

  // column and row counters
  assign col_inc = LW'(col_r) + LW'(1);
  assign row_inc = row_r + 16'd1;
  assign rend    = col_inc >= eff_len;
  assign iend    = rend && ((row_inc >= eff_rows) || (row_inc == 16'd0));

  always_comb begin
    await_nxt = await_r;
    filt_nxt  = filt_r;
    bad_nxt   = bad_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    if (s1_fire) begin
      if (await_r) begin
        // filter type byte opens a row
        await_nxt = 1'b0;
        col_nxt   = '0;
        if (s1_x_r > 8'(FILT_PAETH)) begin
          bad_nxt  = 1'b1;
          filt_nxt = FILT_NONE;
        end else begin
          bad_nxt  = 1'b0;
          filt_nxt = s1_x_r[2:0];
        end
      end else if (rend) begin
        await_nxt = 1'b1;
        col_nxt   = '0;
        row_nxt   = iend ? 16'd0 : row_inc;
      end else begin
        col_nxt = col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      await_r <= 1'b1;
      filt_r  <= FILT_NONE;
      bad_r   <= 1'b0;
      col_r   <= '0;
      row_r   <= 16'd0;
    end else begin
      await_r <= await_nxt;
      filt_r  <= filt_nxt;
      bad_r   <= bad_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
    end
  end

  // history shift lines advance once per data byte
  always_ff @(posedge clk) begin
    if (s1_fire && s1_data) begin
      lh_r[0] <= recon;
      ah_r[0] <= b;
      for (int i = 1; i < MAX_BPP; i++) begin
        lh_r[i] <= lh_r[i-1];
        ah_r[i] <= ah_r[i-1];
      end
    end
  end

  // previous-row store, read one column ahead of processing
  psu_ram #(
    .WIDTH (8),
    .DEPTH (MAX_ROW_BYTES)
  ) u_row_store (
    .clk     (clk),
    .we      (s1_fire && s1_data),
    .waddr   (col_r),
    .wdata   (recon),
    .raddr   (col_nxt),
    .rdata_r (ram_q)
  );

  // output register
  always_comb begin
    out_v_nxt = out_v_r && out_stall;
    if (s1_fire && s1_data) begin
      out_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_data) begin
      out_pix_r  <= recon;
      out_rend_r <= rend;
      out_iend_r <= iend;
      out_bad_r  <= bad_r;
    end
  end

  assign out_valid      = out_v_r;
  assign out_pixel_byte = out_pix_r;
  assign out_row_end    = out_rend_r;
  assign out_image_end  = out_iend_r;
  assign out_bad_filter = out_bad_r;

  // checks
  `PSU_ASSERT(a_img_end_row, out_v_r |-> (!out_iend_r || out_rend_r), "image end without row end")
  `PSU_ASSERT(a_row_end_await, (s1_fire && s1_data && rend) |=> await_r, "row end did not rearm")
  `PSU_ASSERT(a_s1_hold, (s1_v_r && !s1_fire) |=> (s1_v_r && $stable(s1_x_r)), "input reg lost")

endmodule

`default_nettype wire
